// File: sv/perspective_warp_address_map_top_assert.svh
// assertion macros for the perspective warp address map checker
// no dependencies
`ifndef PERSPECTIVE_WARP_ADDRESS_MAP_TOP_ASSERT_SVH
`define PERSPECTIVE_WARP_ADDRESS_MAP_TOP_ASSERT_SVH

// same-cycle implication
`define PWAM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pwam assertion failed");

// next-cycle implication
`define PWAM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pwam assertion failed");

`endif

// File: sv/pwam_pkg.sv
// shared types and constants of the perspective warp address map
// no dependencies
package pwam_pkg;

    localparam int COEF_W    = 48;
    localparam int COORD_W   = 11;
    localparam int PROD_W    = COEF_W + COORD_W + 1;
    localparam int SUM_W     = 62;
    localparam int QUOT_W    = 11;
    localparam int CMP_W     = SUM_W + QUOT_W;
    localparam int IDX_W     = 22;
    localparam int NUM_REGS  = 8;
    localparam int CFG_IDX_W = 4;
    localparam int NUM_STG   = 3 + QUOT_W + 1;

    localparam logic [CFG_IDX_W-1:0] REG_M_XX = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_M_XY = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_M_X0 = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_M_YX = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_M_YY = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_M_Y0 = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_M_WX = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_M_WY = 4'd7;

    typedef struct packed {
        logic signed [COEF_W-1:0] m_xx;
        logic signed [COEF_W-1:0] m_xy;
        logic signed [COEF_W-1:0] m_x0;
        logic signed [COEF_W-1:0] m_yx;
        logic signed [COEF_W-1:0] m_yy;
        logic signed [COEF_W-1:0] m_y0;
        logic signed [COEF_W-1:0] m_wx;
        logic signed [COEF_W-1:0] m_wy;
    } coef_t;

    typedef struct packed {
        logic [SUM_W-1:0]  rem_x;
        logic [SUM_W-1:0]  rem_y;
        logic [SUM_W-1:0]  den;
        logic [QUOT_W-1:0] quo_x;
        logic [QUOT_W-1:0] quo_y;
        logic              neg_x;
        logic              neg_y;
        logic              bad;
    } div_t;

endpackage

// File: sv/pwam_front.sv
// front end: products, sums, magnitudes and range pre-check (three stages)
// depends on pwam_pkg
module pwam_front #(
    parameter int FRAC_BITS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pwam_pkg::coef_t               coef,
    input  logic [2:0]                    en,
    input  logic                          in_valid,
    input  logic [pwam_pkg::COORD_W-1:0]  in_x,
    input  logic [pwam_pkg::COORD_W-1:0]  in_y,
    output logic [2:0]                    valid,
    output pwam_pkg::div_t                d_out
);
    localparam logic signed [pwam_pkg::SUM_W-1:0] ONE =
        pwam_pkg::SUM_W'(1) << FRAC_BITS;
    localparam logic [pwam_pkg::SUM_W-1:0] FRAC_MASK =
        (pwam_pkg::SUM_W'(1) << FRAC_BITS) - pwam_pkg::SUM_W'(1);

    logic signed [pwam_pkg::PROD_W-1:0] p_xx_reg, p_xy_reg, p_yx_reg;
    logic signed [pwam_pkg::PROD_W-1:0] p_yy_reg, p_wx_reg, p_wy_reg;
    logic signed [pwam_pkg::SUM_W-1:0]  nx_reg, ny_reg, dw_reg;
    logic signed [pwam_pkg::SUM_W-1:0]  nx_next, ny_next, dw_next;
    logic [2:0]                         valid_reg;
    pwam_pkg::div_t                     d_reg, d_next;

    logic signed [pwam_pkg::COORD_W:0] sx, sy;
    logic [pwam_pkg::SUM_W-1:0]        abs_x, abs_y, abs_w;
    logic [pwam_pkg::CMP_W-1:0]        lim;

    assign sx = $signed({1'b0, in_x});
    assign sy = $signed({1'b0, in_y});

    always_comb
    begin
        nx_next = pwam_pkg::SUM_W'(p_xx_reg) + pwam_pkg::SUM_W'(p_xy_reg)
                + pwam_pkg::SUM_W'(coef.m_x0);
        ny_next = pwam_pkg::SUM_W'(p_yx_reg) + pwam_pkg::SUM_W'(p_yy_reg)
                + pwam_pkg::SUM_W'(coef.m_y0);
        dw_next = pwam_pkg::SUM_W'(p_wx_reg) + pwam_pkg::SUM_W'(p_wy_reg) + ONE;
    end

    always_comb
    begin
        abs_x = nx_reg[pwam_pkg::SUM_W-1] ? pwam_pkg::SUM_W'(-nx_reg) : nx_reg;
        abs_y = ny_reg[pwam_pkg::SUM_W-1] ? pwam_pkg::SUM_W'(-ny_reg) : ny_reg;
        abs_w = dw_reg[pwam_pkg::SUM_W-1] ? pwam_pkg::SUM_W'(-dw_reg) : dw_reg;
        lim   = {abs_w, {pwam_pkg::QUOT_W{1'b0}}};
        d_next.rem_x = abs_x & ~FRAC_MASK;
        d_next.rem_y = abs_y & ~FRAC_MASK;
        d_next.den   = abs_w;
        d_next.quo_x = '0;
        d_next.quo_y = '0;
        d_next.neg_x = nx_reg[pwam_pkg::SUM_W-1] ^ dw_reg[pwam_pkg::SUM_W-1];
        d_next.neg_y = ny_reg[pwam_pkg::SUM_W-1] ^ dw_reg[pwam_pkg::SUM_W-1];
        d_next.bad   = (dw_reg == '0)
                     || (pwam_pkg::CMP_W'(d_next.rem_x) >= lim)
                     || (pwam_pkg::CMP_W'(d_next.rem_y) >= lim);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0]) valid_reg[0] <= in_valid;
            if (en[1]) valid_reg[1] <= valid_reg[0];
            if (en[2]) valid_reg[2] <= valid_reg[1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            p_xx_reg <= coef.m_xx * sx;
            p_xy_reg <= coef.m_xy * sy;
            p_yx_reg <= coef.m_yx * sx;
            p_yy_reg <= coef.m_yy * sy;
            p_wx_reg <= coef.m_wx * sx;
            p_wy_reg <= coef.m_wy * sy;
        end
        if (en[1])
        begin
            nx_reg <= nx_next;
            ny_reg <= ny_next;
            dw_reg <= dw_next;
        end
        if (en[2])
        begin
            d_reg <= d_next;
        end
    end

    assign valid = valid_reg;
    assign d_out = d_reg;

endmodule

// File: sv/pwam_div_step.sv
// one restoring division stage for both coordinate lanes
// depends on pwam_pkg
module pwam_div_step #(
    parameter int SHIFT = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            valid_in,
    input  pwam_pkg::div_t  d_in,
    output logic            valid_out,
    output pwam_pkg::div_t  d_out
);
    logic                       valid_reg;
    pwam_pkg::div_t             d_reg, d_next;
    logic [pwam_pkg::CMP_W-1:0] dsh, rx, ry;

    always_comb
    begin
        dsh    = pwam_pkg::CMP_W'(d_in.den) << SHIFT;
        rx     = pwam_pkg::CMP_W'(d_in.rem_x);
        ry     = pwam_pkg::CMP_W'(d_in.rem_y);
        d_next = d_in;
        if (rx >= dsh)
        begin
            d_next.rem_x        = pwam_pkg::SUM_W'(rx - dsh);
            d_next.quo_x[SHIFT] = 1'b1;
        end
        if (ry >= dsh)
        begin
            d_next.rem_y        = pwam_pkg::SUM_W'(ry - dsh);
            d_next.quo_y[SHIFT] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            d_reg <= d_next;
    end

    assign valid_out = valid_reg;
    assign d_out     = d_reg;

endmodule

// File: sv/pwam_back.sv
// back end: sign and bound check, linear index, output register
// depends on pwam_pkg
module pwam_back #(
    parameter int SRC_WIDTH  = 1024,
    parameter int SRC_HEIGHT = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          valid_in,
    input  pwam_pkg::div_t                d_in,
    output logic                          valid_out,
    output logic [pwam_pkg::COORD_W-1:0]  src_x,
    output logic [pwam_pkg::COORD_W-1:0]  src_y,
    output logic [pwam_pkg::IDX_W-1:0]    src_index,
    output logic                          outside
);
    localparam int XW = pwam_pkg::COORD_W + 1;

    logic                         valid_reg;
    logic [pwam_pkg::COORD_W-1:0] sx_reg, sy_reg;
    logic [pwam_pkg::IDX_W-1:0]   idx_reg, idx_next;
    logic                         out_reg, out_next;
    logic [pwam_pkg::IDX_W:0]     prod;

    always_comb
    begin
        out_next = d_in.bad
                 || (d_in.neg_x && (d_in.quo_x != '0))
                 || (d_in.neg_y && (d_in.quo_y != '0))
                 || ({1'b0, d_in.quo_x} >= XW'(SRC_WIDTH))
                 || ({1'b0, d_in.quo_y} >= XW'(SRC_HEIGHT));
        prod     = (pwam_pkg::IDX_W+1)'(d_in.quo_y) * (pwam_pkg::IDX_W+1)'(SRC_WIDTH);
        idx_next = pwam_pkg::IDX_W'(prod) + pwam_pkg::IDX_W'(d_in.quo_x);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
            sx_reg  <= out_next ? '0 : d_in.quo_x;
            sy_reg  <= out_next ? '0 : d_in.quo_y;
            idx_reg <= out_next ? '0 : idx_next;
        end
    end

    assign valid_out = valid_reg;
    assign src_x     = sx_reg;
    assign src_y     = sy_reg;
    assign src_index = idx_reg;
    assign outside   = out_reg;

endmodule

// File: sv/perspective_warp_address_map_top.sv
// top level of the perspective warp address map
// depends on pwam_pkg, pwam_front, pwam_div_step, pwam_back
//
// One output pixel coordinate per transaction in, one source address per transaction
// out, one item per clock sustained while the output accepts. The stages are three
// front stages (products, sums, magnitudes with range check), eleven restoring
// division stages that each resolve one quotient bit for both coordinates, and
// the output register. Stalls collapse bubbles stage by stage, so input keeps
// flowing while a result waits. The user must write coefficients through the cfg channel
// only while the pipeline is empty (unenforced); indexes beyond the list are ignored.
module perspective_warp_address_map_top #(
    parameter int SRC_WIDTH  = 1024,
    parameter int SRC_HEIGHT = 1024,
    parameter int FRAC_BITS  = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [23:0]                     s_axis_tdata,  // out_x, out_y, pad
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [47:0]                     m_axis_tdata,  // src_x, src_y, src_index, pad
    output logic                            m_axis_tuser,  // outside
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pwam_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pwam_pkg::COEF_W-1:0]     cfg_data
);
    localparam int NS = pwam_pkg::NUM_STG;
    localparam int NQ = pwam_pkg::QUOT_W;
    localparam logic [pwam_pkg::COEF_W-1:0] ONE = pwam_pkg::COEF_W'(1) << FRAC_BITS;

    pwam_pkg::coef_t                coef_reg;
    logic [NS-1:0]                  en, valid;
    pwam_pkg::div_t                 d [NQ+1];
    logic [pwam_pkg::COORD_W-1:0]   src_x, src_y;
    logic [pwam_pkg::IDX_W-1:0]     src_index;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg.m_xx <= ONE;
            coef_reg.m_xy <= '0;
            coef_reg.m_x0 <= '0;
            coef_reg.m_yx <= '0;
            coef_reg.m_yy <= ONE;
            coef_reg.m_y0 <= '0;
            coef_reg.m_wx <= '0;
            coef_reg.m_wy <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                pwam_pkg::REG_M_XX: coef_reg.m_xx <= cfg_data;
                pwam_pkg::REG_M_XY: coef_reg.m_xy <= cfg_data;
                pwam_pkg::REG_M_X0: coef_reg.m_x0 <= cfg_data;
                pwam_pkg::REG_M_YX: coef_reg.m_yx <= cfg_data;
                pwam_pkg::REG_M_YY: coef_reg.m_yy <= cfg_data;
                pwam_pkg::REG_M_Y0: coef_reg.m_y0 <= cfg_data;
                pwam_pkg::REG_M_WX: coef_reg.m_wx <= cfg_data;
                pwam_pkg::REG_M_WY: coef_reg.m_wy <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    always_comb
    begin
        en[NS-1] = !valid[NS-1] || m_axis_tready;
        for (int k = NS - 2; k >= 0; k--)
            en[k] = !valid[k] || en[k+1];
    end

    assign s_axis_tready = en[0];

    pwam_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .coef     (coef_reg),
        .en       (en[2:0]),
        .in_valid (s_axis_tvalid),
        .in_x     (s_axis_tdata[10:0]),
        .in_y     (s_axis_tdata[21:11]),
        .valid    (valid[2:0]),
        .d_out    (d[0])
    );

    for (genvar i = 0; i < NQ; i++)
    begin : g_div
        pwam_div_step #(
            .SHIFT (NQ - 1 - i)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en[3+i]),
            .valid_in  (valid[2+i]),
            .d_in      (d[i]),
            .valid_out (valid[3+i]),
            .d_out     (d[i+1])
        );
    end

    pwam_back #(
        .SRC_WIDTH  (SRC_WIDTH),
        .SRC_HEIGHT (SRC_HEIGHT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en[NS-1]),
        .valid_in  (valid[NS-2]),
        .d_in      (d[NQ]),
        .valid_out (valid[NS-1]),
        .src_x     (src_x),
        .src_y     (src_y),
        .src_index (src_index),
        .outside   (m_axis_tuser)
    );

    assign m_axis_tvalid = valid[NS-1];
    assign m_axis_tdata  = {4'b0, src_index, src_y, src_x};

endmodule

// File: sv/pwam_checker.sv
// port-level checker for the perspective warp address map, with its bind
// depends on perspective_warp_address_map_top_assert.svh
`include "perspective_warp_address_map_top_assert.svh"

module pwam_checker #(
    parameter int SRC_WIDTH  = 1024,
    parameter int SRC_HEIGHT = 1024
) (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic        m_axis_tuser
);
    `PWAM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `PWAM_ASSERT_NOW(a_outside_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 48'd0)
    `PWAM_ASSERT_NOW(a_in_bounds, m_axis_tvalid && !m_axis_tuser, ({1'b0, m_axis_tdata[10:0]} < 12'(SRC_WIDTH)) && ({1'b0, m_axis_tdata[21:11]} < 12'(SRC_HEIGHT)))
    `PWAM_ASSERT_NOW(a_index, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[43:22] == 22'(23'(m_axis_tdata[21:11]) * 23'(SRC_WIDTH) + 23'(m_axis_tdata[10:0])))

endmodule

bind perspective_warp_address_map_top pwam_checker #(
    .SRC_WIDTH  (SRC_WIDTH),
    .SRC_HEIGHT (SRC_HEIGHT)
) u_pwam_checker (.*);

// File: tb/sv/perspective_warp_address_map_top_tb.sv
// self-checking testbench of the perspective warp address map
// depends on pwam_pkg and perspective_warp_address_map_top
module perspective_warp_address_map_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SRC_WIDTH  = 1024;
    localparam int SRC_HEIGHT = 1024;
    localparam int FRAC_BITS  = 32;
    localparam int LATENCY    = 15;
    localparam int WATCHDOG   = 20000;
    localparam logic signed [47:0] ONE = 48'sd1 <<< FRAC_BITS;
    localparam logic signed [47:0] CMAX = {1'b0, {47{1'b1}}};
    localparam logic signed [47:0] CMIN = {1'b1, {47{1'b0}}};

    typedef struct packed {
        logic [10:0] src_x;
        logic [10:0] src_y;
        logic [21:0] src_index;
        logic        outside;
    } addr_t;

    typedef struct {
        logic [10:0] x;
        logic [10:0] y;
        bit          typed;
        addr_t       want;
    } pix_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [pwam_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [pwam_pkg::COEF_W-1:0]    cfg_data;

    logic signed [47:0] coef [pwam_pkg::NUM_REGS];
    addr_t       addr_q[$];
    int          send_idle;
    int          recv_stall;
    int          stall_cnt;
    bit          failed;
    bit          done;

    perspective_warp_address_map_top #(
        .SRC_WIDTH (SRC_WIDTH),
        .SRC_HEIGHT(SRC_HEIGHT),
        .FRAC_BITS (FRAC_BITS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic signed [63:0] trunc_div(logic signed [63:0] a,
                                                     logic signed [63:0] b);
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] mq;
        ma = a[63] ? -a : a;
        mb = b[63] ? -b : b;
        mq = ma / mb;
        return (a[63] ^ b[63]) ? -$signed(mq) : $signed(mq);
    endfunction

    function automatic addr_t map_pixel(logic [10:0] px, logic [10:0] py);
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [63:0] one;
        logic signed [63:0] nx;
        logic signed [63:0] ny;
        logic signed [63:0] dw;
        logic signed [63:0] qx;
        logic signed [63:0] qy;
        addr_t r;
        x   = {53'd0, px};
        y   = {53'd0, py};
        one = 64'sd1 <<< FRAC_BITS;
        nx  = 64'(coef[pwam_pkg::REG_M_XX]) * x + 64'(coef[pwam_pkg::REG_M_XY]) * y
            + 64'(coef[pwam_pkg::REG_M_X0]);
        ny  = 64'(coef[pwam_pkg::REG_M_YX]) * x + 64'(coef[pwam_pkg::REG_M_YY]) * y
            + 64'(coef[pwam_pkg::REG_M_Y0]);
        dw  = 64'(coef[pwam_pkg::REG_M_WX]) * x + 64'(coef[pwam_pkg::REG_M_WY]) * y + one;
        r   = '0;
        r.outside = 1'b1;
        if (dw != 0)
        begin
            qx = trunc_div(trunc_div(nx, one) * one, dw);
            qy = trunc_div(trunc_div(ny, one) * one, dw);
            if (qx >= 0 && qy >= 0 && qx < SRC_WIDTH && qy < SRC_HEIGHT)
            begin
                r.src_x     = qx[10:0];
                r.src_y     = qy[10:0];
                r.src_index = 22'(qy * SRC_WIDTH + qx);
                r.outside   = 1'b0;
            end
        end
        return r;
    endfunction

    task automatic write_coef(logic [pwam_pkg::CFG_IDX_W-1:0] idx, logic signed [47:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx < pwam_pkg::NUM_REGS)
            coef[idx] = val;
        @(posedge clk);
    endtask

    task automatic send_pixel(logic [10:0] x, logic [10:0] y, bit typed, addr_t want);
        addr_t exp_addr;
        while (send_idle > 0 && $urandom_range(99) < send_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        exp_addr = map_pixel(x, y);
        if (typed && exp_addr != want)
            $display("%0t: table row (%0d,%0d) disagrees: expected %h predicted %h",
                     $time, x, y, want, exp_addr);
        addr_q.push_back(typed ? want : exp_addr);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, y, x};
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (addr_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic random_coefs(int mode);
        int i;
        for (i = 0; i < pwam_pkg::NUM_REGS; i++)
        begin
            case (mode)
                0: write_coef(i[pwam_pkg::CFG_IDX_W-1:0],
                              48'($signed({$urandom, $urandom}) >>> 16));
                1: write_coef(i[pwam_pkg::CFG_IDX_W-1:0], ($urandom_range(1) ? CMAX : CMIN));
                default: write_coef(i[pwam_pkg::CFG_IDX_W-1:0],
                                    48'($signed($urandom_range(6000)) - 3000)
                                    <<< (FRAC_BITS - 12));
            endcase
        end
    endtask

    task automatic random_pixels(int n, bit small_range);
        int k;
        for (k = 0; k < n; k++)
        begin
            if (small_range)
                send_pixel(11'($urandom_range(1100)), 11'($urandom_range(1100)), 1'b0, '0);
            else
                send_pixel(11'($urandom), 11'($urandom), 1'b0, '0);
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n || recv_stall == 0)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall);
    end

    always @(posedge clk)
    begin
        addr_t got;
        addr_t exp_addr;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.src_x     = m_axis_tdata[10:0];
            got.src_y     = m_axis_tdata[21:11];
            got.src_index = m_axis_tdata[43:22];
            got.outside   = m_axis_tuser;
            if (addr_q.size() == 0)
            begin
                $display("%0t: unexpected transaction, actual %h", $time, got);
                failed = 1'b1;
            end
            else
            begin
                exp_addr = addr_q.pop_front();
                if (got != exp_addr)
                begin
                    $display("%0t: mismatch expected x=%0d y=%0d idx=%0d out=%0b, actual x=%0d y=%0d idx=%0d out=%0b",
                             $time, exp_addr.src_x, exp_addr.src_y, exp_addr.src_index,
                             exp_addr.outside, got.src_x, got.src_y, got.src_index,
                             got.outside);
                    failed = 1'b1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= WATCHDOG && !done)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        pix_row_t dir_rows [$];
        int i;
        int phase;
        done          = 1'b0;
        failed        = 1'b0;
        send_idle     = 0;
        recv_stall    = 0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        for (i = 0; i < pwam_pkg::NUM_REGS; i++)
            coef[i] = '0;
        coef[pwam_pkg::REG_M_XX] = ONE;
        coef[pwam_pkg::REG_M_YY] = ONE;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // identity after reset
        dir_rows.push_back('{0, 0, 1'b1, '{0, 0, 0, 1'b0}});
        dir_rows.push_back('{1023, 1023, 1'b1, '{1023, 1023, 22'd1048575, 1'b0}});
        dir_rows.push_back('{1024, 5, 1'b1, '{0, 0, 0, 1'b1}});
        dir_rows.push_back('{5, 1024, 1'b1, '{0, 0, 0, 1'b1}});
        dir_rows.push_back('{2047, 2047, 1'b1, '{0, 0, 0, 1'b1}});
        dir_rows.push_back('{3, 2, 1'b1, '{3, 2, 22'd2051, 1'b0}});
        dir_rows.push_back('{1023, 0, 1'b0, '0});
        dir_rows.push_back('{0, 1023, 1'b0, '0});
        foreach (dir_rows[i])
            send_pixel(dir_rows[i].x, dir_rows[i].y, dir_rows[i].typed, dir_rows[i].want);
        drain();

        // zero denominator at x = 1, negative quotient, huge quotient
        write_coef(pwam_pkg::REG_M_WX, -ONE);
        write_coef(pwam_pkg::REG_M_X0, 48'sd5 <<< FRAC_BITS);
        write_coef(pwam_pkg::REG_M_WY, 48'sd1 <<< (FRAC_BITS - 20));
        write_coef(4'd9, CMAX);
        send_pixel(1, 0, 1'b1, '{0, 0, 0, 1'b1});
        send_pixel(0, 0, 1'b0, '0);
        send_pixel(2, 0, 1'b0, '0);
        send_pixel(0, 7, 1'b0, '0);
        send_pixel(2047, 2047, 1'b0, '0);
        drain();
        write_coef(pwam_pkg::REG_M_WX, '0);
        write_coef(pwam_pkg::REG_M_WY, -(48'sd1 <<< (FRAC_BITS - 11)));
        write_coef(pwam_pkg::REG_M_XY, CMIN);
        write_coef(pwam_pkg::REG_M_YX, CMAX);
        write_coef(pwam_pkg::REG_M_Y0, -(48'sd3 <<< FRAC_BITS));
        send_pixel(0, 0, 1'b0, '0);
        send_pixel(1, 0, 1'b0, '0);
        send_pixel(0, 2047, 1'b0, '0);
        send_pixel(2047, 0, 1'b0, '0);
        send_pixel(1024, 1024, 1'b0, '0);
        drain();

        for (phase = 0; phase < 12; phase++)
        begin
            case (phase % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 66; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 66; end
                default: begin send_idle = 6; recv_stall = 6; end
            endcase
            // mostly near-identity homographies, so points land inside
            if (phase == 5)
                random_coefs(1);
            else if (phase % 3 == 0)
                random_coefs(0);
            else
            begin
                write_coef(pwam_pkg::REG_M_XX,
                           ONE + 48'($signed($urandom_range(8192)) - 4096) * 64);
                write_coef(pwam_pkg::REG_M_XY, 48'($signed($urandom_range(8192)) - 4096) * 64);
                write_coef(pwam_pkg::REG_M_X0,
                           48'($signed($urandom_range(400)) - 200) <<< FRAC_BITS);
                write_coef(pwam_pkg::REG_M_YX, 48'($signed($urandom_range(8192)) - 4096) * 64);
                write_coef(pwam_pkg::REG_M_YY,
                           ONE + 48'($signed($urandom_range(8192)) - 4096) * 64);
                write_coef(pwam_pkg::REG_M_Y0, 48'({$urandom, $urandom} >> 16));
                write_coef(pwam_pkg::REG_M_WX, 48'($signed($urandom_range(2000)) - 1000) * 2);
                write_coef(pwam_pkg::REG_M_WY, 48'($signed($urandom_range(2000)) - 1000) * 2);
            end
            random_pixels(75, (phase % 2) == 0);
            drain();
        end

        done = 1'b1;
        if (!failed)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: sim.f
+incdir+sv
sv/pwam_pkg.sv
sv/pwam_front.sv
sv/pwam_div_step.sv
sv/pwam_back.sv
sv/perspective_warp_address_map_top.sv
sv/pwam_checker.sv
tb/sv/perspective_warp_address_map_top_tb.sv
